>>> sv/dmt_pkg.sv
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared types and constants for the direct-mapped translation buffer.
// ----------------------------------------------------------------------------
package dmt_pkg;

    // Field widths
    localparam int VA_W    = 32;
    localparam int VPN_W   = 20;
    localparam int FRAME_W = 20;
    localparam int SHIFT_W = 5;
    localparam int CNT_W   = 32;

    // Request actions
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_FILL   = 2'd1;
    localparam logic [1:0] ACT_INVAL  = 2'd2;

    // Page shift limits and reset value
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    // One stored translation entry
    typedef struct packed {
        logic               valid;
        logic [VPN_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
    } entry_t;

endpackage

>>> sv/direct_mapped_tlb.sv
// ----------------------------------------------------------------------------
// direct_mapped_tlb
// Direct-mapped translation buffer with configurable page size.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with action, virtual_address and
//   frame_number. Each request gives exactly one result on out_valid/
//   out_ready: hit, physical_address and the hit and miss totals.
//   A request passes from acceptance to result through ST_MUL1 and ST_MUL2,
//   the reciprocal multiply that forms the entry index, ST_READ, the
//   memory read, and ST_WB, in which the read data arrives, the entry is
//   written back and the output register loads. One request is in flight
//   at a time, so the next request is accepted only after the last one's
//   write-back, once the block is idle again.
//   cfg_we writes cfg_wdata into the page shift register;
//   write it only while no request is in flight.
//   After reset the block sweeps the entry memory, clearing one entry a
//   cycle until every entry is cleared; in_ready stays low during the sweep.
//   When the receiver stalls, the result holds in the output register; a
//   new request is still accepted and waits at write-back until the
//   result is taken.
// ----------------------------------------------------------------------------
module direct_mapped_tlb #(
    parameter int TLB_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dmt_pkg::SHIFT_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [dmt_pkg::VA_W-1:0]    virtual_address,
    input  logic [dmt_pkg::FRAME_W-1:0] frame_number,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [dmt_pkg::VA_W-1:0]    physical_address,
    output logic [dmt_pkg::CNT_W-1:0]   hit_total,
    output logic [dmt_pkg::CNT_W-1:0]   miss_total
);
    import dmt_pkg::*;

    localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [SHIFT_W-1:0] offset_bits_reg;
    logic [CNT_W-1:0]   hit_cnt_reg, miss_cnt_reg;
    logic               out_valid_reg;

    logic [1:0]         action_reg;
    logic [VPN_W-1:0]   vpn_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [VA_W-1:0]    offset_reg;
    logic               hit_reg;
    logic [VA_W-1:0]    pa_reg;

    logic [SHIFT_W-1:0] shift;
    logic               in_fire;
    logic               wb_fire;
    logic               entry_hit;
    logic [IDX_W-1:0]   idx;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    entry_t             mem_rdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign wb_fire   = (state_reg == ST_WB) && (!out_valid_reg || out_ready);
    assign entry_hit = mem_rdata.valid && (mem_rdata.tag == vpn_reg);

    // Clamp page shift to its legal range
    always_comb
    begin
        shift = offset_bits_reg;
        if (shift < SHIFT_MIN)
        begin
            shift = SHIFT_MIN;
        end
        else if (shift > SHIFT_MAX)
        begin
            shift = SHIFT_MAX;
        end
    end

    // Index unit and entry memory
    dmt_index #(.TLB_DEPTH(TLB_DEPTH)) u_index (
        .clk (clk),
        .vpn (vpn_reg),
        .idx (idx)
    );

    dmt_mem #(.TLB_DEPTH(TLB_DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx),
        .rdata (mem_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(TLB_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_READ;
            ST_READ:  state_next = ST_WB;
            ST_WB:
            begin
                if (wb_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Memory write: clearing sweep, fill, or invalidate on tag match
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (wb_fire)
        begin
            unique case (action_reg)
                ACT_FILL:
                begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.tag   = vpn_reg;
                    mem_wdata.frame = frame_reg;
                end
                ACT_INVAL:
                begin
                    mem_we          = entry_hit;
                    mem_wdata.valid = 1'b0;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            offset_bits_reg <= SHIFT_RESET;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cfg_we)
            begin
                offset_bits_reg <= cfg_wdata;
            end
            // Saturating counters, lookups only
            if (wb_fire && (action_reg == ACT_LOOKUP))
            begin
                if (entry_hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(hit_cnt_reg != '1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(miss_cnt_reg != '1);
                end
            end
            if (wb_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            vpn_reg    <= VPN_W'(virtual_address >> shift);
            offset_reg <= virtual_address & ((VA_W'(1) << shift) - VA_W'(1));
            frame_reg  <= frame_number;
            shift_reg  <= shift;
        end
        if (wb_fire)
        begin
            if ((action_reg == ACT_LOOKUP) && entry_hit)
            begin
                hit_reg <= 1'b1;
                pa_reg  <= (VA_W'(mem_rdata.frame) << shift_reg) + offset_reg;
            end
            else
            begin
                hit_reg <= 1'b0;
                pa_reg  <= '0;
            end
        end
    end

    // Counters change only when a new result loads, so they track it
    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign physical_address = pa_reg;
    assign hit_total        = hit_cnt_reg;
    assign miss_total       = miss_cnt_reg;

`ifndef ASSERT_OFF
    // No request taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request accepted during clearing sweep");

    // Index unit stays within the memory
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (32'(idx) < TLB_DEPTH))
        else $error("entry index out of range");

    // Memory written only by the sweep or at write-back
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_WB)))
        else $error("memory write outside sweep or write-back");

    // Counters never decrease
    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((hit_cnt_reg >= $past(hit_cnt_reg)) && (miss_cnt_reg >= $past(miss_cnt_reg))))
        else $error("hit or miss counter decreased");

    // A reported hit has been counted
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (hit_cnt_reg != '0))
        else $error("hit reported with zero hit count");
`endif

endmodule

>>> sv/dmt_index.sv
// ----------------------------------------------------------------------------
// dmt_index
// Page number modulo depth by reciprocal multiplication: two registered
// multiplies (prod_reg, qd_reg), then one compare and subtract; input held.
// ----------------------------------------------------------------------------
module dmt_index #(
    parameter int TLB_DEPTH = 64,
    localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
    input  logic                      clk,
    input  logic [dmt_pkg::VPN_W-1:0] vpn,
    output logic [IDX_W-1:0]          idx
);
    import dmt_pkg::*;

    localparam int PROD_W = VPN_W + 32;
    localparam int DEP_W  = $clog2(TLB_DEPTH + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TLB_DEPTH);
    localparam logic [VPN_W-1:0] DEPTH_V = VPN_W'(TLB_DEPTH);

    logic [PROD_W-1:0]        prod_reg;
    logic [VPN_W-1:0]         qd_reg;
    logic [VPN_W+DEP_W-1:0]   qd_full;
    logic [VPN_W-1:0]         rem;

    // Quotient estimate is exact or one low
    assign qd_full = (VPN_W+DEP_W)'(prod_reg[PROD_W-1:32]) * (VPN_W+DEP_W)'(TLB_DEPTH);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(vpn) * PROD_W'(RECIP);
        qd_reg   <= qd_full[VPN_W-1:0];
    end

    // Remainder below twice the depth: one correction step
    always_comb
    begin
        rem = vpn - qd_reg;
        if (rem >= DEPTH_V)
        begin
            rem = rem - DEPTH_V;
        end
        idx = rem[IDX_W-1:0];
    end

endmodule

>>> sv/dmt_mem.sv
// ----------------------------------------------------------------------------
// dmt_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dmt_mem #(
    parameter int TLB_DEPTH = 64,
    localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  dmt_pkg::entry_t  wdata,
    input  logic [IDX_W-1:0] raddr,
    output dmt_pkg::entry_t  rdata
);
    import dmt_pkg::*;

    entry_t mem [TLB_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sim/direct_mapped_tlb_test.sv
// ----------------------------------------------------------------------------
// direct_mapped_tlb_test
// Self-checking bench for the direct-mapped translation buffer. A short table
// of directed requests, then random fill/lookup/invalidate/no-op traffic over
// several page shifts. Every hit and address is checked against the table or
// a software model of the entry memory, and the totals against the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_mapped_tlb_test;

    import dmt_pkg::*;

    localparam int TLB_DEPTH = 64;
    localparam int RAND_PER_SHIFT = 228;
    localparam int POOL_MAX = 16;

    // Unused action code, decoded as a no-op
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         act;
        logic [VA_W-1:0]    va;
        logic [FRAME_W-1:0] frame;
        logic               pinned;
        logic               exp_hit;
        logic [VA_W-1:0]    exp_pa;
    } row_t;

    typedef struct packed {
        logic             hit;
        logic [VA_W-1:0]  pa;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } xlat_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [SHIFT_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          action;
    logic [VA_W-1:0]     virtual_address;
    logic [FRAME_W-1:0]  frame_number;
    logic                out_valid;
    logic                out_ready;
    logic                hit;
    logic [VA_W-1:0]     physical_address;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;

    // Model state
    logic [VPN_W-1:0]    tag_mem   [TLB_DEPTH];
    logic [FRAME_W-1:0]  frame_mem [TLB_DEPTH];
    logic                valid_mem [TLB_DEPTH];
    logic [CNT_W-1:0]    hit_count;
    logic [CNT_W-1:0]    miss_count;
    logic [SHIFT_W-1:0]  shift_reg;

    xlat_t               pending_xlat[$];
    row_t                script[$];
    logic [VA_W-1:0]     live_pages[$];

    int                  errors;
    int                  burst_left;
    int                  n_lookups, n_fills, n_invals, n_nops, n_hits_seen, n_cfg;
    int unsigned         rx_cycle;
    logic [1:0]          rx_mode;

    direct_mapped_tlb #(
        .TLB_DEPTH(TLB_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .virtual_address(virtual_address),
        .frame_number(frame_number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .physical_address(physical_address),
        .hit_total(hit_total),
        .miss_total(miss_total)
    );

    // Clock
    always #5 clk = ~clk;

    // Page shift actually used, register clamped to the legal range
    function automatic int page_shift(logic [SHIFT_W-1:0] raw);
        if (raw < SHIFT_MIN)
            return int'(SHIFT_MIN);
        if (raw > SHIFT_MAX)
            return int'(SHIFT_MAX);
        return int'(raw);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // Translate one request and update the model's entries and totals
    function automatic xlat_t translate(logic [1:0] act, logic [VA_W-1:0] va,
                                        logic [FRAME_W-1:0] frame);
        int               sh;
        logic [VPN_W-1:0] vpn;
        logic [VA_W-1:0]  offset;
        int               idx;
        xlat_t            r;
        sh = page_shift(shift_reg);
        vpn = VPN_W'(va >> sh);
        offset = va & ((32'd1 << sh) - 32'd1);
        idx = int'(vpn) % TLB_DEPTH;
        r = '0;
        case (act)
            ACT_LOOKUP:
            begin
                if (valid_mem[idx] && tag_mem[idx] == vpn)
                begin
                    r.hit = 1'b1;
                    r.pa = (VA_W'(frame_mem[idx]) << sh) + offset;
                    hit_count = sat_inc(hit_count);
                end
                else
                    miss_count = sat_inc(miss_count);
            end
            ACT_FILL:
            begin
                tag_mem[idx] = vpn;
                frame_mem[idx] = frame;
                valid_mem[idx] = 1'b1;
            end
            ACT_INVAL:
            begin
                for (int j = 0; j < TLB_DEPTH; j++)
                    if (valid_mem[j] && tag_mem[j] == vpn)
                        valid_mem[j] = 1'b0;
            end
            default: ;
        endcase
        r.hits = hit_count;
        r.misses = miss_count;
        return r;
    endfunction

    function automatic row_t req_row(logic [1:0] act, logic [VA_W-1:0] va,
                                     logic [FRAME_W-1:0] frame, logic pinned,
                                     logic exp_hit, logic [VA_W-1:0] exp_pa);
        row_t r;
        r.kind = ROW_REQ;
        r.act = act;
        r.va = va;
        r.frame = frame;
        r.pinned = pinned;
        r.exp_hit = exp_hit;
        r.exp_pa = exp_pa;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [SHIFT_W-1:0] value);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.va = VA_W'(value);
        return r;
    endfunction

    // Issue one request; returns after its acceptance and any gap that follows.
    // Pinned rows take hit and address from the table, totals from the model.
    task automatic send_request(logic [1:0] act, logic [VA_W-1:0] va,
                                logic [FRAME_W-1:0] frame, logic pinned,
                                logic exp_hit, logic [VA_W-1:0] exp_pa);
        xlat_t p;
        action <= act;
        virtual_address <= va;
        frame_number <= frame;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p = translate(act, va, frame);
        if (pinned)
        begin
            p.hit = exp_hit;
            p.pa = exp_pa;
        end
        pending_xlat.push_back(p);
        case (act)
            ACT_LOOKUP: n_lookups++;
            ACT_FILL:   n_fills++;
            ACT_INVAL:  n_invals++;
            default:    n_nops++;
        endcase
        // Burst / gap pattern on the request side
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Write the page shift once the block has drained
    task automatic write_page_shift(logic [SHIFT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_xlat.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shift_reg = value;
        n_cfg++;
    endtask

    task automatic note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
        $display("%0t: %s mismatch: expected %h actual %h", $time, field, exp_v, act_v);
        errors++;
    endtask

    // Result side: check each accepted result, then pick the next stall value
    always @(posedge clk)
    begin
        xlat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_xlat.size() == 0)
            begin
                $display("%0t: unexpected result: hit %0d pa %h", $time, hit,
                         physical_address);
                errors++;
            end
            else
            begin
                e = pending_xlat.pop_front();
                if (hit !== e.hit)
                    note_mismatch("hit", 32'(e.hit), 32'(hit));
                if (physical_address !== e.pa)
                    note_mismatch("physical_address", e.pa, physical_address);
                if (hit_total !== e.hits)
                    note_mismatch("hit_total", e.hits, hit_total);
                if (miss_total !== e.misses)
                    note_mismatch("miss_total", e.misses, miss_total);
                if (hit === 1'b1)
                    n_hits_seen++;
            end
        end
        rx_cycle++;
        if (rx_cycle % 128 == 0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (rx_cycle % 4 == 0);
            default: out_ready <= (rx_cycle % 16 > 11);
        endcase
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("direct_mapped_tlb test failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [SHIFT_W-1:0] phase_shift [8];
        logic [VA_W-1:0]    base, mask, va;
        logic [1:0]         act;
        int                 sel, sh, drain;
        row_t               r;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = ACT_LOOKUP;
        virtual_address = '0;
        frame_number = '0;
        out_ready = 1'b0;
        rx_mode = 2'd0;
        rx_cycle = 0;
        errors = 0;
        burst_left = 0;
        n_lookups = 0;
        n_fills = 0;
        n_invals = 0;
        n_nops = 0;
        n_hits_seen = 0;
        n_cfg = 0;

        // Model reset
        for (int i = 0; i < TLB_DEPTH; i++)
        begin
            tag_mem[i] = '0;
            frame_mem[i] = '0;
            valid_mem[i] = 1'b0;
        end
        hit_count = '0;
        miss_count = '0;
        shift_reg = SHIFT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, 4 KiB pages out of reset
        script.push_back(req_row(ACT_LOOKUP, 32'h0000_0000, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'hFFFF_FFFF, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_FILL,   32'h0000_0000, 20'hFFFFF, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'h0000_0FFF, 20'h0, 1, 1, 32'hFFFF_FFFF));
        script.push_back(req_row(ACT_FILL,   32'hFFFF_FFFF, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'hFFFF_F123, 20'h0, 1, 1, 32'h0000_0123));
        // same index, other tag: miss, then the fill evicts
        script.push_back(req_row(ACT_LOOKUP, 32'h0004_0000, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_FILL,   32'h0004_0000, 20'h12345, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'h0000_0000, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'h0004_0ABC, 20'h0, 1, 1, 32'h1234_5ABC));
        // invalidate a match, then one with no match
        script.push_back(req_row(ACT_INVAL,  32'h0004_0000, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'h0004_0000, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_INVAL,  32'h0008_0000, 20'h0, 1, 0, 32'h0));
        // unused action code leaves the entries alone
        script.push_back(req_row(ACT_NOP,    32'hFFFF_FFFF, 20'hFFFFF, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'hFFFF_F000, 20'h0, 1, 1, 32'h0));
        script.push_back(req_row(ACT_FILL,   32'h5555_5555, 20'hAAAAA, 0, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'hAAAA_AAAA, 20'h0, 1, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'h5555_5AAA, 20'h0, 1, 1, 32'hAAAA_AAAA));
        // shift above range clamps to 30
        script.push_back(cfg_row(5'd31));
        script.push_back(req_row(ACT_FILL,   32'hC000_0000, 20'h00002, 0, 0, 32'h0));
        script.push_back(req_row(ACT_LOOKUP, 32'hFFFF_FFFF, 20'h0, 1, 1, 32'hBFFF_FFFF));
        script.push_back(req_row(ACT_LOOKUP, 32'h5555_5AAA, 20'h0, 1, 0, 32'h0));
        // shift below range clamps to 12; old entries survive the change
        script.push_back(cfg_row(5'd0));
        script.push_back(req_row(ACT_LOOKUP, 32'h5555_5AAA, 20'h0, 1, 1, 32'hAAAA_AAAA));
        script.push_back(req_row(ACT_LOOKUP, 32'h0000_3456, 20'h0, 1, 1, 32'h0000_2456));
        script.push_back(req_row(ACT_LOOKUP, 32'hC000_0123, 20'h0, 0, 0, 32'h0));

        foreach (script[i])
        begin
            r = script[i];
            if (r.kind == ROW_CFG)
                write_page_shift(r.va[SHIFT_W-1:0]);
            else
                send_request(r.act, r.va, r.frame, r.pinned, r.exp_hit, r.exp_pa);
        end

        // Random traffic over a range of page sizes
        phase_shift[0] = 5'd30;
        phase_shift[1] = 5'd12;
        phase_shift[2] = 5'd31;
        phase_shift[3] = 5'd20;
        phase_shift[4] = 5'd0;
        phase_shift[5] = 5'($urandom_range(0, 31));
        phase_shift[6] = 5'd16;
        phase_shift[7] = 5'($urandom_range(12, 30));

        for (int ph = 0; ph < 8; ph++)
        begin
            write_page_shift(phase_shift[ph]);
            sh = page_shift(shift_reg);
            mask = (32'd1 << sh) - 32'd1;
            for (int n = 0; n < RAND_PER_SHIFT; n++)
            begin
                sel = $urandom_range(0, 99);
                base = (live_pages.size() > 0) ?
                       live_pages[$urandom_range(0, live_pages.size() - 1)] : $urandom;
                va = $urandom;
                if (sel < 30)
                begin
                    act = ACT_FILL;
                    if ($urandom_range(0, 3) == 0)
                        va = (base & ~mask) | (va & mask);
                    live_pages.push_back(va);
                    if (live_pages.size() > POOL_MAX)
                        void'(live_pages.pop_front());
                end
                else if (sel < 80)
                begin
                    act = ACT_LOOKUP;
                    if ($urandom_range(0, 9) < 7)
                        va = (base & ~mask) | (va & mask);
                end
                else if (sel < 94)
                begin
                    act = ACT_INVAL;
                    if ($urandom_range(0, 9) < 7)
                        va = (base & ~mask) | (va & mask);
                end
                else
                    act = ACT_NOP;
                send_request(act, va, 20'($urandom), 1'b0, 1'b0, '0);
            end
        end

        // Drain and let the pipeline settle
        in_valid <= 1'b0;
        drain = 0;
        while (pending_xlat.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (pending_xlat.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_xlat.size());
            errors++;
        end

        $display("Covered %0d lookups (%0d hits), %0d fills, %0d invalidates, %0d no-ops",
                 n_lookups, n_hits_seen, n_fills, n_invals, n_nops);
        $display("across %0d page shift writes; %0d mismatches", n_cfg, errors);
        if (errors == 0)
            $display("direct_mapped_tlb test passed");
        else
            $display("direct_mapped_tlb test failed");
        $finish;
    end

endmodule
